FILE: src/bec_pkg.sv
// ----------------------------------------------------------------------------
// bec_pkg
// Shared types and constants of the 3D binary erosion core.
// ----------------------------------------------------------------------------
package bec_pkg;

	localparam int MAX_DIM_DEF = 64;
	localparam int MAX_BOX     = 7;

	localparam int COORD_W = 6;
	localparam int VSIZE_W = 7;
	localparam int BOX_W   = 3;
	localparam int VAL_W   = 8;
	localparam int POS_W   = 9;
	localparam int IDX_W   = 4;

	typedef enum logic [IDX_W-1:0] {
		REG_VOL_SIZE_0 = 4'd0,
		REG_VOL_SIZE_1 = 4'd1,
		REG_VOL_SIZE_2 = 4'd2,
		REG_BOX_SIZE_0 = 4'd3,
		REG_BOX_SIZE_1 = 4'd4,
		REG_BOX_SIZE_2 = 4'd5,
		REG_BORDER     = 4'd6,
		REG_CENTER     = 4'd7
	} reg_idx_t;

	typedef struct packed {
		logic [POS_W-1:0] n0;
		logic [POS_W-1:0] n1;
		logic [POS_W-1:0] n2;
		logic [BOX_W-1:0] b0;
		logic [BOX_W-1:0] b1;
		logic [BOX_W-1:0] b2;
		logic             border_true;
		logic             center_must_be_set;
	} cfg_t;

endpackage

FILE: src/bec_ram.sv
// ----------------------------------------------------------------------------
// bec_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module bec_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 262144
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: src/bec_seq.sv
// ----------------------------------------------------------------------------
// bec_seq
// Query sequencer: optional centre check, then a box scan with one memory read
// per in-volume neighbour and evaluation in the cycle after the issued read.
// ----------------------------------------------------------------------------
module bec_seq #(
	parameter int MAX_DIM = bec_pkg::MAX_DIM_DEF,
	localparam int DIM_W  = $clog2(MAX_DIM),
	localparam int ADDR_W = 3 * DIM_W
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bec_pkg::cfg_t                cfg,
	input  logic                         start,
	input  logic                         func,
	input  logic [bec_pkg::COORD_W-1:0]  coord_0,
	input  logic [bec_pkg::COORD_W-1:0]  coord_1,
	input  logic [bec_pkg::COORD_W-1:0]  coord_2,
	output logic                         busy,
	output logic                         done,
	output logic                         eroded,
	output logic                         rd_en,
	output logic [ADDR_W-1:0]            rd_addr,
	input  logic                         rd_data
);

	typedef enum logic [1:0] {S_IDLE, S_CENTER, S_ISSUE, S_DRAIN} state_t;

	state_t state_q;
	logic [bec_pkg::COORD_W-1:0] c0_q, c1_q, c2_q;
	logic [bec_pkg::BOX_W-1:0]   i0_q, i1_q, i2_q;
	logic v_s1, out_s1;
	logic done_q, eroded_q;

	logic [bec_pkg::POS_W-1:0] e0, e1, e2, p0, p1, p2;
	logic accept, in_vol, empty_box, outside, last, fail_s1;
	logic end2, end1;

	assign accept = start && !busy && func;
	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign eroded = eroded_q;

	always_comb begin
		e0 = {3'b000, coord_0};
		e1 = {3'b000, coord_1};
		e2 = {3'b000, coord_2};
		in_vol = (e0 < cfg.n0) && (e1 < cfg.n1) && (e2 < cfg.n2);
		empty_box = (cfg.b0 == '0) || (cfg.b1 == '0) || (cfg.b2 == '0);
		p0 = {3'b000, c0_q} - {7'b0, cfg.b0[2:1]} + {6'b0, i0_q};
		p1 = {3'b000, c1_q} - {7'b0, cfg.b1[2:1]} + {6'b0, i1_q};
		p2 = {3'b000, c2_q} - {7'b0, cfg.b2[2:1]} + {6'b0, i2_q};
		outside = p0[bec_pkg::POS_W-1] || (p0 >= cfg.n0)
			|| p1[bec_pkg::POS_W-1] || (p1 >= cfg.n1)
			|| p2[bec_pkg::POS_W-1] || (p2 >= cfg.n2);
		end2 = (i2_q == cfg.b2 - 3'd1);
		end1 = (i1_q == cfg.b1 - 3'd1);
		last = (i0_q == cfg.b0 - 3'd1) && end1 && end2;
		fail_s1 = v_s1 && (out_s1 ? !cfg.border_true : !rd_data);
		if (state_q == S_ISSUE) begin
			rd_en   = !outside;
			rd_addr = {p0[DIM_W-1:0], p1[DIM_W-1:0], p2[DIM_W-1:0]};
		end else begin
			rd_en   = accept && in_vol && cfg.center_must_be_set;
			rd_addr = {e0[DIM_W-1:0], e1[DIM_W-1:0], e2[DIM_W-1:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			v_s1     <= 1'b0;
			out_s1   <= 1'b0;
			done_q   <= 1'b0;
			eroded_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (!in_vol) begin
							done_q   <= 1'b1;
							eroded_q <= 1'b0;
						end else if (cfg.center_must_be_set) begin
							state_q <= S_CENTER;
						end else if (empty_box) begin
							done_q   <= 1'b1;
							eroded_q <= 1'b1;
						end else begin
							state_q <= S_ISSUE;
						end
					end
				end
				S_CENTER: begin
					if (!rd_data) begin
						done_q   <= 1'b1;
						eroded_q <= 1'b0;
						state_q  <= S_IDLE;
					end else if (empty_box) begin
						done_q   <= 1'b1;
						eroded_q <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: begin
					v_s1    <= 1'b1;
					out_s1  <= outside;
					if (fail_s1) begin
						v_s1     <= 1'b0;
						done_q   <= 1'b1;
						eroded_q <= 1'b0;
						state_q  <= S_IDLE;
					end else if (last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					v_s1     <= 1'b0;
					done_q   <= 1'b1;
					eroded_q <= !fail_s1;
					state_q  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// box counters, fastest axis innermost
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			c0_q <= coord_0;
			c1_q <= coord_1;
			c2_q <= coord_2;
		end
		if (state_q != S_ISSUE) begin
			i0_q <= '0;
			i1_q <= '0;
			i2_q <= '0;
		end else if (end2) begin
			i2_q <= '0;
			if (end1) begin
				i1_q <= '0;
				i0_q <= i0_q + 3'd1;
			end else begin
				i1_q <= i1_q + 3'd1;
			end
		end else begin
			i2_q <= i2_q + 3'd1;
		end
	end

endmodule

FILE: src/binary_erosion_3d_core.sv
// ----------------------------------------------------------------------------
// binary_erosion_3d_core
// 3D binary erosion with a box structuring element over a stored volume.
//
// Items are taken on start while busy is low. func 0 loads one voxel bit
// (set when voxel_value is nonzero) in the cycle of the transfer and leaves
// busy low, so the next item may follow at once. func 1 queries the eroded
// value at coord_0..2; eroded appears with a one-cycle done strobe.
// A query outside the volume answers in the cycle after its transfer. Else
// the centre is read first if the centre check is on; an empty box answers
// then, others scan the box with one volume read per in-volume neighbour,
// each evaluated in the cycle after, stopping at the first clear voxel (an
// outside one when the border is clear); the single read port paces the scan.
// Configuration writes go over cfg_valid/cfg_ready (ready is always high);
// the user must make them while busy is low, as the core does not enforce
// it. Reset restores the register defaults and clears the sequencer; the
// volume memory is not cleared and a voxel reads as undefined until loaded.
// The result has no back pressure: done is a plain strobe.
// ----------------------------------------------------------------------------
module binary_erosion_3d_core #(
	parameter int MAX_DIM = bec_pkg::MAX_DIM_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [bec_pkg::IDX_W-1:0]    cfg_index,
	input  logic [bec_pkg::VSIZE_W-1:0]  cfg_data,
	input  logic                         start,
	output logic                         busy,
	input  logic                         func,
	input  logic [bec_pkg::COORD_W-1:0]  coord_0,
	input  logic [bec_pkg::COORD_W-1:0]  coord_1,
	input  logic [bec_pkg::COORD_W-1:0]  coord_2,
	input  logic [bec_pkg::VAL_W-1:0]    voxel_value,
	output logic                         done,
	output logic                         eroded
);

	localparam int DIM_W  = $clog2(MAX_DIM);
	localparam int ADDR_W = 3 * DIM_W;
	localparam int DEPTH  = 1 << ADDR_W;
	localparam logic [bec_pkg::POS_W-1:0] DIM_LIM = bec_pkg::POS_W'(MAX_DIM);
	localparam logic [bec_pkg::BOX_W-1:0] BOX_LIM = bec_pkg::BOX_W'(bec_pkg::MAX_BOX);

	logic [bec_pkg::VSIZE_W-1:0] vs0_q, vs1_q, vs2_q;
	logic [bec_pkg::BOX_W-1:0]   bs0_q, bs1_q, bs2_q;
	logic                        border_q, center_q;
	bec_pkg::cfg_t               cfg;

	logic [bec_pkg::POS_W-1:0] e0, e1, e2, x0, x1, x2;
	logic                      we;
	logic [ADDR_W-1:0]         waddr, rd_addr;
	logic                      rd_en, rd_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vs0_q    <= 7'd64;
			vs1_q    <= 7'd64;
			vs2_q    <= 7'd64;
			bs0_q    <= 3'd3;
			bs1_q    <= 3'd3;
			bs2_q    <= 3'd3;
			border_q <= 1'b0;
			center_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bec_pkg::REG_VOL_SIZE_0: vs0_q    <= cfg_data;
				bec_pkg::REG_VOL_SIZE_1: vs1_q    <= cfg_data;
				bec_pkg::REG_VOL_SIZE_2: vs2_q    <= cfg_data;
				bec_pkg::REG_BOX_SIZE_0: bs0_q    <= cfg_data[bec_pkg::BOX_W-1:0];
				bec_pkg::REG_BOX_SIZE_1: bs1_q    <= cfg_data[bec_pkg::BOX_W-1:0];
				bec_pkg::REG_BOX_SIZE_2: bs2_q    <= cfg_data[bec_pkg::BOX_W-1:0];
				bec_pkg::REG_BORDER:     border_q <= cfg_data[0];
				bec_pkg::REG_CENTER:     center_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// clamp sizes to the store and box limits
	always_comb begin
		x0 = {2'b00, vs0_q};
		x1 = {2'b00, vs1_q};
		x2 = {2'b00, vs2_q};
		cfg.n0 = (x0 > DIM_LIM) ? DIM_LIM : x0;
		cfg.n1 = (x1 > DIM_LIM) ? DIM_LIM : x1;
		cfg.n2 = (x2 > DIM_LIM) ? DIM_LIM : x2;
		cfg.b0 = (bs0_q > BOX_LIM) ? BOX_LIM : bs0_q;
		cfg.b1 = (bs1_q > BOX_LIM) ? BOX_LIM : bs1_q;
		cfg.b2 = (bs2_q > BOX_LIM) ? BOX_LIM : bs2_q;
		cfg.border_true        = border_q;
		cfg.center_must_be_set = center_q;
	end

	// voxel load, dropped when beyond the store
	always_comb begin
		e0 = {3'b000, coord_0};
		e1 = {3'b000, coord_1};
		e2 = {3'b000, coord_2};
		we = start && !busy && !func
			&& (e0 < DIM_LIM) && (e1 < DIM_LIM) && (e2 < DIM_LIM);
		waddr = {e0[DIM_W-1:0], e1[DIM_W-1:0], e2[DIM_W-1:0]};
	end

	bec_ram #(
		.WIDTH(1),
		.DEPTH(DEPTH)
	) u_volume (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (voxel_value != '0),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	bec_seq #(
		.MAX_DIM(MAX_DIM)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.start   (start),
		.func    (func),
		.coord_0 (coord_0),
		.coord_1 (coord_1),
		.coord_2 (coord_2),
		.busy    (busy),
		.done    (done),
		.eroded  (eroded),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

endmodule

FILE: test/binary_erosion_3d_core_tb.sv
// ----------------------------------------------------------------------------
// binary_erosion_3d_core_tb
// Self-checking bench for the 3D binary erosion core. Voxel loads and
// erosion queries go in through the start/busy handshake and the registers
// through the cfg channel. A bit-level model of the volume and the registers
// works out each eroded answer, and every done strobe is checked against the
// oldest answer still owed. A directed opening covers register extremes,
// empty and clamped sizes, border and centre handling. Random phases follow,
// each with its own register setting. Every voxel that a query can read is
// loaded before that query is sent.
// ----------------------------------------------------------------------------
module binary_erosion_3d_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD  = 8;
	localparam int STORE_DEPTH = bec_pkg::MAX_DIM_DEF * bec_pkg::MAX_DIM_DEF
		* bec_pkg::MAX_DIM_DEF;
	localparam int ITEM_TARGET = 1300;
	localparam int QUIET_LIMIT = 4000;
	localparam int SCAN_CYCLES = bec_pkg::MAX_BOX * bec_pkg::MAX_BOX * bec_pkg::MAX_BOX + 3;
	localparam int MAX_GAP     = 9;
	localparam int MAX_REPORTS = 10;
	localparam int WINDOW      = 8;

	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	localparam logic [bec_pkg::IDX_W-1:0] SPARE_IDX_LO = 4'd8;
	localparam logic [bec_pkg::IDX_W-1:0] SPARE_IDX_HI = 4'd15;

	typedef struct {
		logic                        func;
		logic [bec_pkg::COORD_W-1:0] c0;
		logic [bec_pkg::COORD_W-1:0] c1;
		logic [bec_pkg::COORD_W-1:0] c2;
		logic [bec_pkg::VAL_W-1:0]   value;
		int                          gap;
	} voxel_op_t;

	typedef struct {
		bit eroded;
		int c0;
		int c1;
		int c2;
	} eroded_answer_t;

	logic                         clk         = 1'b0;
	logic                         arst_n      = 1'b0;
	logic                         cfg_valid   = 1'b0;
	logic                         cfg_ready;
	logic [bec_pkg::IDX_W-1:0]    cfg_index   = '0;
	logic [bec_pkg::VSIZE_W-1:0]  cfg_data    = '0;
	logic                         start       = 1'b0;
	logic                         busy;
	logic                         func        = 1'b0;
	logic [bec_pkg::COORD_W-1:0]  coord_0     = '0;
	logic [bec_pkg::COORD_W-1:0]  coord_1     = '0;
	logic [bec_pkg::COORD_W-1:0]  coord_2     = '0;
	logic [bec_pkg::VAL_W-1:0]    voxel_value = '0;
	logic                         done;
	logic                         eroded;

	voxel_op_t      pending_items[$];
	eroded_answer_t eroded_due[$];
	voxel_op_t      next_op;
	eroded_answer_t owed;
	eroded_answer_t posted;

	bit vol_bits [STORE_DEPTH];
	bit primed   [STORE_DEPTH];

	int vol_size [3] = '{64, 64, 64};
	int box_size [3] = '{3, 3, 3};
	bit border_set   = 1'b0;
	bit center_check = 1'b1;

	int win_lo [3] = '{0, 0, 0};
	int set_pct     = 70;
	bit burst_phase = 1'b0;

	int queued_total = 0;
	int taken_total  = 0;
	int fail_count   = 0;
	int quiet_cycles = 0;
	int gap_count    = 0;
	bit took_item    = 1'b0;

	binary_erosion_3d_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.coord_0     (coord_0),
		.coord_1     (coord_1),
		.coord_2     (coord_2),
		.voxel_value (voxel_value),
		.done        (done),
		.eroded      (eroded)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic int dim_of(input int a);
		return (vol_size[a] > bec_pkg::MAX_DIM_DEF) ? bec_pkg::MAX_DIM_DEF : vol_size[a];
	endfunction

	function automatic int voxel_addr(input int c0, input int c1, input int c2);
		return (c0 * bec_pkg::MAX_DIM_DEF + c1) * bec_pkg::MAX_DIM_DEF + c2;
	endfunction

	function automatic bit eroded_at(input int c0, input int c1, input int c2);
		int n0, n1, n2, p0, p1, p2;
		bit outside;
		n0 = dim_of(0);
		n1 = dim_of(1);
		n2 = dim_of(2);
		if (c0 >= n0 || c1 >= n1 || c2 >= n2)
			return 1'b0;
		if (center_check && !vol_bits[voxel_addr(c0, c1, c2)])
			return 1'b0;
		for (int i0 = 0; i0 < box_size[0]; i0++) begin
			p0 = c0 - box_size[0] / 2 + i0;
			for (int i1 = 0; i1 < box_size[1]; i1++) begin
				p1 = c1 - box_size[1] / 2 + i1;
				for (int i2 = 0; i2 < box_size[2]; i2++) begin
					p2 = c2 - box_size[2] / 2 + i2;
					outside = p0 < 0 || p0 >= n0 || p1 < 0 || p1 >= n1 || p2 < 0 || p2 >= n2;
					if (outside) begin
						if (!border_set)
							return 1'b0;
					end else if (!vol_bits[voxel_addr(p0, p1, p2)]) begin
						return 1'b0;
					end
				end
			end
		end
		return 1'b1;
	endfunction

	function automatic void apply_reg(input logic [bec_pkg::IDX_W-1:0] idx,
			input logic [bec_pkg::VSIZE_W-1:0] data);
		case (idx)
			bec_pkg::REG_VOL_SIZE_0: vol_size[0] = data;
			bec_pkg::REG_VOL_SIZE_1: vol_size[1] = data;
			bec_pkg::REG_VOL_SIZE_2: vol_size[2] = data;
			bec_pkg::REG_BOX_SIZE_0: box_size[0] = data[bec_pkg::BOX_W-1:0];
			bec_pkg::REG_BOX_SIZE_1: box_size[1] = data[bec_pkg::BOX_W-1:0];
			bec_pkg::REG_BOX_SIZE_2: box_size[2] = data[bec_pkg::BOX_W-1:0];
			bec_pkg::REG_BORDER:     border_set = data[0];
			bec_pkg::REG_CENTER:     center_check = data[0];
			default: ;
		endcase
	endfunction

	function automatic void report_fail(input string msg);
		if (fail_count < MAX_REPORTS)
			$display("%s", msg);
		fail_count++;
	endfunction

	function automatic void queue_op(input logic f, input int c0, input int c1, input int c2,
			input logic [bec_pkg::VAL_W-1:0] value);
		voxel_op_t op;
		op.func  = f;
		op.c0    = bec_pkg::COORD_W'(c0);
		op.c1    = bec_pkg::COORD_W'(c1);
		op.c2    = bec_pkg::COORD_W'(c2);
		op.value = value;
		op.gap   = burst_phase ? 0 : $urandom_range(0, MAX_GAP);
		if (f == FUNC_LOAD)
			primed[voxel_addr(op.c0, op.c1, op.c2)] = 1'b1;
		pending_items.push_back(op);
		queued_total++;
	endfunction

	function automatic logic [bec_pkg::VAL_W-1:0] fill_value();
		if ($urandom_range(0, 99) < set_pct)
			return bec_pkg::VAL_W'($urandom_range(1, 255));
		return '0;
	endfunction

	function automatic void prime_voxel(input int c0, input int c1, input int c2);
		if (!primed[voxel_addr(c0, c1, c2)])
			queue_op(FUNC_LOAD, c0, c1, c2, fill_value());
	endfunction

	// load every voxel the query may read before sending it
	function automatic void plan_query(input int c0, input int c1, input int c2);
		int n0, n1, n2, p0, p1, p2;
		n0 = dim_of(0);
		n1 = dim_of(1);
		n2 = dim_of(2);
		if (c0 < n0 && c1 < n1 && c2 < n2) begin
			prime_voxel(c0, c1, c2);
			for (int i0 = 0; i0 < box_size[0]; i0++) begin
				p0 = c0 - box_size[0] / 2 + i0;
				for (int i1 = 0; i1 < box_size[1]; i1++) begin
					p1 = c1 - box_size[1] / 2 + i1;
					for (int i2 = 0; i2 < box_size[2]; i2++) begin
						p2 = c2 - box_size[2] / 2 + i2;
						if (p0 >= 0 && p0 < n0 && p1 >= 0 && p1 < n1 && p2 >= 0 && p2 < n2)
							prime_voxel(p0, p1, p2);
					end
				end
			end
		end
		queue_op(FUNC_QUERY, c0, c1, c2, bec_pkg::VAL_W'($urandom));
	endfunction

	function automatic int pick_coord(input int a);
		int c;
		c = win_lo[a] + $urandom_range(0, WINDOW - 1);
		return (c > bec_pkg::MAX_DIM_DEF - 1) ? bec_pkg::MAX_DIM_DEF - 1 : c;
	endfunction

	task automatic write_reg(input logic [bec_pkg::IDX_W-1:0] idx,
			input logic [bec_pkg::VSIZE_W-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		apply_reg(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic wait_idle(input int tail);
		while (taken_total != queued_total || eroded_due.size() != 0 || busy)
			@(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	// driver
	always @(negedge clk) begin
		if (!start || took_item) begin
			if (pending_items.size() == 0) begin
				start <= 1'b0;
			end else if (gap_count < pending_items[0].gap) begin
				start     <= 1'b0;
				gap_count <= gap_count + 1;
			end else begin
				next_op = pending_items.pop_front();
				start       <= 1'b1;
				func        <= next_op.func;
				coord_0     <= next_op.c0;
				coord_1     <= next_op.c1;
				coord_2     <= next_op.c2;
				voxel_value <= next_op.value;
				gap_count   <= 0;
			end
		end
	end

	// monitor, predictor and watchdog
	always @(posedge clk) begin
		took_item <= start && !busy;
		if (arst_n && done) begin
			if (eroded_due.size() == 0) begin
				report_fail($sformatf("eroded=%0b with no query outstanding", eroded));
			end else begin
				owed = eroded_due.pop_front();
				if (eroded !== owed.eroded)
					report_fail($sformatf("query (%0d,%0d,%0d): expected eroded=%0b, got %b",
						owed.c0, owed.c1, owed.c2, owed.eroded, eroded));
			end
		end
		if (start && !busy) begin
			taken_total++;
			if (func == FUNC_QUERY) begin
				posted.eroded = eroded_at(coord_0, coord_1, coord_2);
				posted.c0     = coord_0;
				posted.c1     = coord_1;
				posted.c2     = coord_2;
				eroded_due.push_back(posted);
			end else begin
				vol_bits[voxel_addr(coord_0, coord_1, coord_2)] = (voxel_value != '0);
			end
		end
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL binary_erosion_3d_core");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int r, box, n, phase_start, phase_len;
		logic [bec_pkg::VSIZE_W-1:0] data;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset register values, value byte extremes, corner queries
		queue_op(FUNC_LOAD, 0, 0, 0, 8'hFF);
		queue_op(FUNC_LOAD, 0, 0, 1, 8'h01);
		queue_op(FUNC_LOAD, 0, 1, 0, 8'h80);
		queue_op(FUNC_LOAD, 1, 0, 0, 8'h00);
		plan_query(0, 0, 0);
		plan_query(1, 0, 0);
		plan_query(63, 63, 63);

		// empty box, clamped and single-voxel axes, centre check off
		wait_idle(4);
		write_reg(bec_pkg::REG_VOL_SIZE_0, 7'h7F);
		write_reg(bec_pkg::REG_VOL_SIZE_1, 7'(bec_pkg::MAX_DIM_DEF));
		write_reg(bec_pkg::REG_VOL_SIZE_2, 7'd1);
		write_reg(bec_pkg::REG_BOX_SIZE_0, 7'h00);
		write_reg(bec_pkg::REG_BOX_SIZE_1, 7'h08);
		write_reg(bec_pkg::REG_BOX_SIZE_2, 7'h00);
		write_reg(bec_pkg::REG_BORDER, 7'h01);
		write_reg(bec_pkg::REG_CENTER, 7'h7E);
		write_reg(SPARE_IDX_LO, 7'h55);
		plan_query(1, 0, 0);
		plan_query(0, 0, 1);
		plan_query(63, 63, 0);

		// largest box on a tiny volume with a set border
		wait_idle(4);
		write_reg(bec_pkg::REG_VOL_SIZE_0, 7'd2);
		write_reg(bec_pkg::REG_VOL_SIZE_1, 7'd2);
		write_reg(bec_pkg::REG_VOL_SIZE_2, 7'd2);
		write_reg(bec_pkg::REG_BOX_SIZE_0, 7'h7F);
		write_reg(bec_pkg::REG_BOX_SIZE_1, 7'h7F);
		write_reg(bec_pkg::REG_BOX_SIZE_2, 7'h7F);
		write_reg(bec_pkg::REG_CENTER, 7'h01);
		write_reg(SPARE_IDX_HI, 7'h7F);
		plan_query(0, 0, 0);
		for (int i = 0; i < 8; i++)
			queue_op(FUNC_LOAD, i / 4, (i / 2) % 2, i % 2, 8'hFF);
		plan_query(0, 0, 0);
		plan_query(1, 1, 1);

		// empty volume, clear border
		wait_idle(4);
		write_reg(bec_pkg::REG_VOL_SIZE_0, 7'd0);
		write_reg(bec_pkg::REG_VOL_SIZE_1, 7'd5);
		write_reg(bec_pkg::REG_VOL_SIZE_2, 7'd5);
		write_reg(bec_pkg::REG_BORDER, 7'h00);
		plan_query(0, 0, 0);
		plan_query(0, 4, 4);

		while (queued_total < ITEM_TARGET) begin
			wait_idle(4);
			for (int a = 0; a < 3; a++) begin
				r = $urandom_range(0, 99);
				if (r < 70)
					data = 7'($urandom_range(1, 12));
				else if (r < 85)
					data = 7'(bec_pkg::MAX_DIM_DEF);
				else if (r < 95)
					data = 7'($urandom_range(bec_pkg::MAX_DIM_DEF + 1, 127));
				else
					data = '0;
				write_reg(bec_pkg::IDX_W'(bec_pkg::REG_VOL_SIZE_0 + a), data);
			end
			for (int a = 0; a < 3; a++) begin
				box = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3)
					: $urandom_range(0, bec_pkg::MAX_BOX);
				data = {4'($urandom), 3'(box)};
				write_reg(bec_pkg::IDX_W'(bec_pkg::REG_BOX_SIZE_0 + a), data);
			end
			write_reg(bec_pkg::REG_BORDER, 7'($urandom));
			write_reg(bec_pkg::REG_CENTER, 7'($urandom));
			if ($urandom_range(0, 3) == 0)
				write_reg(4'($urandom_range(SPARE_IDX_LO, SPARE_IDX_HI)), 7'($urandom));

			// query window near the low corner or straddling the far face
			for (int a = 0; a < 3; a++) begin
				n = dim_of(a);
				win_lo[a] = ($urandom_range(0, 1) && n > WINDOW) ? n - (WINDOW - 2) : 0;
			end
			r = $urandom_range(0, 2);
			set_pct = (r == 0) ? 50 : (r == 1) ? 85 : 97;
			burst_phase = ($urandom_range(0, 3) == 0);

			phase_start = queued_total;
			phase_len = $urandom_range(60, 140);
			while (queued_total - phase_start < phase_len) begin
				r = $urandom_range(0, 99);
				if (r < 60)
					plan_query(pick_coord(0), pick_coord(1), pick_coord(2));
				else if (r < 85)
					queue_op(FUNC_LOAD, pick_coord(0), pick_coord(1), pick_coord(2), fill_value());
				else
					queue_op(FUNC_LOAD, $urandom_range(0, bec_pkg::MAX_DIM_DEF - 1),
						$urandom_range(0, bec_pkg::MAX_DIM_DEF - 1),
						$urandom_range(0, bec_pkg::MAX_DIM_DEF - 1),
						bec_pkg::VAL_W'($urandom));
			end
		end

		wait_idle(SCAN_CYCLES + 8);
		if (fail_count == 0)
			$display("PASS binary_erosion_3d_core");
		else
			$display("FAIL binary_erosion_3d_core");
		$finish;
	end

endmodule
